### design/tccs_pkg.sv
package tccs_pkg;

  // screen storage geometry
  localparam int unsigned MaxColumns = 128;
  localparam int unsigned MaxRows    = 32;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned AddrW      = RowW + ColW;
  localparam int unsigned CellW      = 16;
  localparam int unsigned Depth      = MaxColumns * MaxRows;

  // character and attribute constants
  localparam logic [7:0] BlankGlyph  = 8'h20;
  localparam logic [7:0] ResetAttr   = 8'h0F;
  localparam logic [7:0] NewlineCode = 8'h0A;

  // configuration register indexes and reset values
  localparam logic [1:0] CfgColumns = 2'd0;
  localparam logic [1:0] CfgRows    = 2'd1;
  localparam logic [1:0] CfgAttr    = 2'd2;
  localparam logic [7:0] ResetCols  = 8'd80;
  localparam logic [5:0] ResetRows  = 6'd25;

  // microprogram step addresses
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_PUTCHK, ST_PUT, ST_NEWROW,
    ST_SCR_START, ST_PRIME, ST_COPY, ST_ROWNEXT, ST_BLANK, ST_DONE,
    ST_FINISH, ST_READ, ST_RDATA, ST_ROWINC
  } step_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NONE, C_ALWAYS, C_NO_ACCEPT, C_OP_READ, C_NEWLINE, C_COL_NOT_END,
    C_ROW_NOT_END, C_ROWS_ONE, C_CNT_NOT_END, C_ROW_NEXT_NOT_END,
    C_CLEARING, C_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_CLAMP, CUR_ADV, CUR_COL_CLR, CUR_ROW_INC
  } cur_op_e;

  typedef enum logic [2:0] {
    CNT_HOLD, CNT_CLR, CNT_INC_ALL, CNT_COL_INC, CNT_ROW_NEXT
  } cnt_op_e;

  typedef enum logic [1:0] {
    WD_RESET_BLANK, WD_GLYPH, WD_COPY, WD_BLANK
  } wd_sel_e;

  typedef enum logic {
    WA_CNT, WA_CURSOR
  } wa_sel_e;

  typedef enum logic [1:0] {
    RA_INPUT, RA_BELOW, RA_BELOW_NEXT
  } ra_sel_e;

  // one control word of the microprogram
  typedef struct packed {
    cond_e   cond;
    step_e   target;
    logic    we;
    wd_sel_e wd_sel;
    wa_sel_e wa_sel;
    ra_sel_e ra_sel;
    cur_op_e cur_op;
    cnt_op_e cnt_op;
    logic    set_scrolled;
    logic    cell_load;
    logic    out_load;
  } ctl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic accept;
    logic op_read;
    logic newline;
    logic col_end;
    logic row_end;
    logic rows_one;
    logic cnt_col_end;
    logic next_row_end;
    logic clear_done;
    logic out_busy;
  } stat_t;

  // effective screen geometry
  typedef struct packed {
    logic [ColW-1:0] cols_m1;
    logic [RowW-1:0] rows_m1;
    logic [7:0]      attr;
  } geom_t;

endpackage

### design/text_console_cursor_scroll_top.sv
// text console with cursor and scroll
//
// input channel: in_valid_i / in_stall_o with operation_i, char_code_i,
// read_column_i and read_row_i; an item is taken when valid is high and
// stall is low. output channel: out_valid_o / out_stall_i, one word per
// item with the cursor after the item, the scroll flag and the read cell.
// configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i
// (0 columns, 1 rows, 2 attribute); ready is always high.
// a microprogram sequencer drives one screen memory with a single write
// and a single read port; one item is worked on at a time.
// put character and read cell each give one result word; a put may wrap
// the cursor to the next row, and a newline moves it to column 0 there. the next
// item can be taken on the edge after the result word appears.
// a scroll copies each row into the one above and blanks the bottom row, one memory
// write per cycle while rows are copied and the bottom row is blanked.
// after reset all 4096 cells of the memory are cleared to blanks with
// attribute 0x0F; in_stall_o stays high until that pass ends.
// a stalled result waits in the output register; the next item is taken
// meanwhile and its result waits until the register is free.
module text_console_cursor_scroll_top
  import tccs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] read_column_i,
  input  logic [4:0] read_row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] cursor_column_o,
  output logic [4:0] cursor_row_o,
  output logic       scrolled_o,
  output logic [7:0] cell_glyph_o,
  output logic [7:0] cell_attribute_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] cols_q;
  logic [5:0] rows_q;
  logic [7:0] attr_q;
  geom_t      geom;
  ctl_t       ctl;
  stat_t      stat;
  logic       idle;
  logic       accept;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ResetCols;
      rows_q <= ResetRows;
      attr_q <= ResetAttr;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgColumns: cols_q <= cfg_data_i;
        CfgRows:    rows_q <= cfg_data_i[5:0];
        CfgAttr:    attr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective geometry: zero counts as one, large values saturate
  always_comb begin
    if (cols_q == '0) begin
      geom.cols_m1 = '0;
    end else if ({1'b0, cols_q} > 9'(MaxColumns)) begin
      geom.cols_m1 = ColW'(MaxColumns - 1);
    end else begin
      geom.cols_m1 = ColW'(cols_q - 8'd1);
    end
    if (rows_q == '0) begin
      geom.rows_m1 = '0;
    end else if ({1'b0, rows_q} > 7'(MaxRows)) begin
      geom.rows_m1 = RowW'(MaxRows - 1);
    end else begin
      geom.rows_m1 = RowW'(rows_q - 6'd1);
    end
    geom.attr = attr_q;
  end

  // input handshake
  assign in_stall_o = !idle;
  assign accept     = in_valid_i && !in_stall_o;

  tccs_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl),
    .idle_o (idle)
  );

  tccs_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .geom_i           (geom),
    .accept_i         (accept),
    .operation_i      (operation_i),
    .char_code_i      (char_code_i),
    .read_column_i    (read_column_i),
    .read_row_i       (read_row_i),
    .out_take_i       (out_valid_o && !out_stall_i),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .scrolled_o       (scrolled_o),
    .cell_glyph_o     (cell_glyph_o),
    .cell_attribute_o (cell_attribute_o)
  );

  // a scrolling put never reports a cell
  a_scroll_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cell_glyph_o == 8'd0 && cell_attribute_o == 8'd0)
    else $error("scrolled result carries cell data");

  // the sequencer leaves idle right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("item taken without leaving idle");

  // a new result only appears from the finishing step
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

### design/tccs_ram.sv
module tccs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/tccs_sequencer.sv
module tccs_sequencer
  import tccs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctl_t  ctl_o,
  output logic  idle_o
);

  step_e step_q, step_d;
  logic  take;

  // microprogram table
  function automatic ctl_t ucode(input step_e s);
    ctl_t w;
    w = '0;
    unique case (s)
      ST_CLEAR: begin
        w.we = 1'b1; w.wd_sel = WD_RESET_BLANK; w.wa_sel = WA_CNT;
        w.cnt_op = CNT_INC_ALL; w.cond = C_CLEARING; w.target = ST_CLEAR;
      end
      ST_IDLE: begin
        w.cond = C_NO_ACCEPT; w.target = ST_IDLE;
      end
      ST_DISPATCH: begin
        w.cond = C_OP_READ; w.target = ST_READ;
      end
      ST_PUTCHK: begin
        w.cur_op = CUR_CLAMP; w.cond = C_NEWLINE; w.target = ST_NEWROW;
      end
      ST_PUT: begin
        w.we = 1'b1; w.wd_sel = WD_GLYPH; w.wa_sel = WA_CURSOR;
        w.cur_op = CUR_ADV; w.cond = C_COL_NOT_END; w.target = ST_DONE;
      end
      ST_NEWROW: begin
        w.cur_op = CUR_COL_CLR; w.cond = C_ROW_NOT_END; w.target = ST_ROWINC;
      end
      ST_SCR_START: begin
        w.set_scrolled = 1'b1; w.cnt_op = CNT_CLR;
        w.cond = C_ROWS_ONE; w.target = ST_BLANK;
      end
      ST_PRIME: begin
        w.ra_sel = RA_BELOW;
      end
      ST_COPY: begin
        w.we = 1'b1; w.wd_sel = WD_COPY; w.wa_sel = WA_CNT;
        w.ra_sel = RA_BELOW_NEXT; w.cnt_op = CNT_COL_INC;
        w.cond = C_CNT_NOT_END; w.target = ST_COPY;
      end
      ST_ROWNEXT: begin
        w.cnt_op = CNT_ROW_NEXT; w.cond = C_ROW_NEXT_NOT_END; w.target = ST_PRIME;
      end
      ST_BLANK: begin
        w.we = 1'b1; w.wd_sel = WD_BLANK; w.wa_sel = WA_CNT;
        w.cnt_op = CNT_COL_INC; w.cond = C_CNT_NOT_END; w.target = ST_BLANK;
      end
      ST_DONE: begin
        w.cond = C_OUT_BUSY; w.target = ST_DONE;
      end
      ST_FINISH: begin
        w.out_load = 1'b1; w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
      ST_READ: begin
        w.ra_sel = RA_INPUT;
      end
      ST_RDATA: begin
        w.cell_load = 1'b1; w.cond = C_ALWAYS; w.target = ST_DONE;
      end
      ST_ROWINC: begin
        w.cur_op = CUR_ROW_INC; w.cond = C_ALWAYS; w.target = ST_DONE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // control word of the current step
  always_comb begin
    ctl_o  = ucode(step_q);
    idle_o = (step_q == ST_IDLE);
  end

  // jump condition select
  always_comb begin
    unique case (ctl_o.cond)
      C_NONE:             take = 1'b0;
      C_ALWAYS:           take = 1'b1;
      C_NO_ACCEPT:        take = !stat_i.accept;
      C_OP_READ:          take = stat_i.op_read;
      C_NEWLINE:          take = stat_i.newline;
      C_COL_NOT_END:      take = !stat_i.col_end;
      C_ROW_NOT_END:      take = !stat_i.row_end;
      C_ROWS_ONE:         take = stat_i.rows_one;
      C_CNT_NOT_END:      take = !stat_i.cnt_col_end;
      C_ROW_NEXT_NOT_END: take = !stat_i.next_row_end;
      C_CLEARING:         take = !stat_i.clear_done;
      C_OUT_BUSY:         take = stat_i.out_busy;
      default:            take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (take) begin
      step_d = ctl_o.target;
    end else begin
      step_d = step_e'(step_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_CLEAR;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### design/tccs_datapath.sv
module tccs_datapath
  import tccs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_t       ctl_i,
  input  geom_t      geom_i,
  input  logic       accept_i,
  input  logic       operation_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] read_column_i,
  input  logic [4:0] read_row_i,
  input  logic       out_take_i,
  output stat_t      stat_o,
  output logic       out_valid_o,
  output logic [6:0] cursor_column_o,
  output logic [4:0] cursor_row_o,
  output logic       scrolled_o,
  output logic [7:0] cell_glyph_o,
  output logic [7:0] cell_attribute_o
);

  // latched item
  logic             op_q;
  logic [7:0]       char_q;
  logic [AddrW-1:0] rd_addr_q;

  // cursor and sweep counters
  logic [ColW-1:0] cur_col_q, cur_col_d;
  logic [RowW-1:0] cur_row_q, cur_row_d;
  logic [ColW-1:0] cnt_col_q, cnt_col_d;
  logic [RowW-1:0] cnt_row_q, cnt_row_d;

  // result under construction and output register
  logic            scrolled_q;
  logic [CellW-1:0] cell_q;
  logic            out_full_q;
  logic [6:0]      out_col_q;
  logic [4:0]      out_row_q;
  logic            out_scr_q;
  logic [CellW-1:0] out_cell_q;

  // memory ports
  logic [AddrW-1:0] waddr, raddr;
  logic [CellW-1:0] wdata, rdata;
  logic [RowW-1:0]  row_below;

  assign row_below = cnt_row_q + RowW'(1);

  // write data select
  always_comb begin
    case (ctl_i.wd_sel)
      WD_RESET_BLANK: wdata = {ResetAttr, BlankGlyph};
      WD_GLYPH:       wdata = {geom_i.attr, char_q};
      WD_COPY:        wdata = rdata;
      WD_BLANK:       wdata = {geom_i.attr, BlankGlyph};
      default:        wdata = {geom_i.attr, BlankGlyph};
    endcase
  end

  // write and read address select
  always_comb begin
    if (ctl_i.wa_sel == WA_CURSOR) begin
      waddr = {cur_row_q, cur_col_q};
    end else begin
      waddr = {cnt_row_q, cnt_col_q};
    end
    case (ctl_i.ra_sel)
      RA_BELOW:      raddr = {row_below, cnt_col_q};
      RA_BELOW_NEXT: raddr = {row_below, cnt_col_q + ColW'(1)};
      default:       raddr = rd_addr_q;
    endcase
  end

  tccs_ram #(
    .Width (CellW),
    .Depth (Depth)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ctl_i.we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // cursor update
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    case (ctl_i.cur_op)
      CUR_CLAMP: begin
        if (cur_col_q > geom_i.cols_m1) cur_col_d = geom_i.cols_m1;
        if (cur_row_q > geom_i.rows_m1) cur_row_d = geom_i.rows_m1;
      end
      CUR_ADV: begin
        if (cur_col_q == geom_i.cols_m1) begin
          cur_col_d = '0;
        end else begin
          cur_col_d = cur_col_q + ColW'(1);
        end
      end
      CUR_COL_CLR: cur_col_d = '0;
      CUR_ROW_INC: cur_row_d = cur_row_q + RowW'(1);
      default: ;
    endcase
  end

  // sweep counter update
  always_comb begin
    cnt_col_d = cnt_col_q;
    cnt_row_d = cnt_row_q;
    case (ctl_i.cnt_op)
      CNT_CLR: begin
        cnt_col_d = '0;
        cnt_row_d = '0;
      end
      CNT_INC_ALL: {cnt_row_d, cnt_col_d} = {cnt_row_q, cnt_col_q} + AddrW'(1);
      CNT_COL_INC: cnt_col_d = cnt_col_q + ColW'(1);
      CNT_ROW_NEXT: begin
        cnt_col_d = '0;
        cnt_row_d = row_below;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      cnt_col_q  <= '0;
      cnt_row_q  <= '0;
      out_full_q <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cnt_col_q <= cnt_col_d;
      cnt_row_q <= cnt_row_d;
      if (ctl_i.out_load) begin
        out_full_q <= 1'b1;
      end else if (out_take_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  // item fields and result payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q       <= operation_i;
      char_q     <= char_code_i;
      rd_addr_q  <= {RowW'(read_row_i), ColW'(read_column_i)};
      scrolled_q <= 1'b0;
      cell_q     <= '0;
    end else begin
      if (ctl_i.set_scrolled) scrolled_q <= 1'b1;
      if (ctl_i.cell_load)    cell_q     <= rdata;
    end
    if (ctl_i.out_load) begin
      out_col_q  <= 7'(cur_col_q);
      out_row_q  <= 5'(cur_row_q);
      out_scr_q  <= scrolled_q;
      out_cell_q <= cell_q;
    end
  end

  // flags for the sequencer
  always_comb begin
    stat_o.accept       = accept_i;
    stat_o.op_read      = op_q;
    stat_o.newline      = (char_q == NewlineCode);
    stat_o.col_end      = (cur_col_q == geom_i.cols_m1);
    stat_o.row_end      = (cur_row_q == geom_i.rows_m1);
    stat_o.rows_one     = (geom_i.rows_m1 == '0);
    stat_o.cnt_col_end  = (cnt_col_q == geom_i.cols_m1);
    stat_o.next_row_end = (row_below == geom_i.rows_m1);
    stat_o.clear_done   = &{cnt_row_q, cnt_col_q};
    stat_o.out_busy     = out_full_q;
  end

  assign out_valid_o      = out_full_q;
  assign cursor_column_o  = out_col_q;
  assign cursor_row_o     = out_row_q;
  assign scrolled_o       = out_scr_q;
  assign cell_glyph_o     = out_cell_q[7:0];
  assign cell_attribute_o = out_cell_q[15:8];

endmodule
